// File: sv/bus_mouse_packet_tracker_assert.svh
// Assertion macros for the bus mouse packet tracker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef BUS_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define BUS_MOUSE_PACKET_TRACKER_ASSERT_SVH

// same-cycle implication
`define BMPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmpt assertion failed");

// next-cycle implication
`define BMPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmpt assertion failed");

`endif

// File: sv/bmpt_pkg.sv
// Package for the bus mouse packet tracker: word types, widths, register map.
// No dependencies.
package bmpt_pkg;

    localparam int BYTE_W             = 8;
    localparam int CURSOR_W           = 12;
    localparam int THR_W              = 7;
    localparam int GAIN_W             = 3;
    localparam int MOTION_W           = 11;
    localparam int COORD_BITS_DEFAULT = 12;
    localparam int ADDR_W             = 4;
    localparam int DATA_W             = 32;

    localparam int MAX_X_RESET  = 639;
    localparam int MAX_Y_RESET  = 479;
    localparam logic [THR_W-1:0]  THR_RESET  = 7'd5;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 3'd2;

    localparam int LEFT_BIT  = 2;
    localparam int RIGHT_BIT = 0;

    localparam logic [1:0] REG_SCREEN_MAX_X    = 2'd0;
    localparam logic [1:0] REG_SCREEN_MAX_Y    = 2'd1;
    localparam logic [1:0] REG_ACCEL_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_ACCEL_GAIN      = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              realign;
    } byte_word_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_x;
        logic [CURSOR_W-1:0] cursor_y;
        logic                left_button;
        logic                right_button;
    } pkt_word_t;

endpackage

// File: sv/bus_mouse_packet_tracker.sv
// Bus mouse packet tracker: three-byte packet decode, acceleration, clamped cursor.
// A packet's third byte waits in the input register and writes its word to the result
// register when it fires. Throughput: one byte per cycle while pkt_ready keeps the
// result register from stalling; one packet word per three bytes.
// Reset: asynchronous, clears control, packet state and cursor; registers take defaults.
// Depends on bmpt_pkg and bus_mouse_packet_tracker_assert.svh.
module bus_mouse_packet_tracker #(
    parameter int COORD_BITS = bmpt_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    output logic                         byte_ready,
    input  bmpt_pkg::byte_word_t         byte_word,
    output logic                         pkt_valid,
    input  logic                         pkt_ready,
    output bmpt_pkg::pkt_word_t          pkt_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmpt_pkg::ADDR_W-1:0]  paddr,
    input  logic [bmpt_pkg::DATA_W-1:0]  pwdata,
    output logic [bmpt_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import bmpt_pkg::*;

    localparam int SUM_W = ((COORD_BITS > MOTION_W) ? COORD_BITS : MOTION_W) + 2;
    localparam int EXT_W = (COORD_BITS > CURSOR_W) ? COORD_BITS : CURSOR_W;
    localparam logic [COORD_BITS-1:0] MAX_X_INIT = COORD_BITS'(MAX_X_RESET);
    localparam logic [COORD_BITS-1:0] MAX_Y_INIT = COORD_BITS'(MAX_Y_RESET);

    typedef enum logic [2:0] {
        PH_HDR = 3'b001,
        PH_X   = 3'b010,
        PH_Y   = 3'b100
    } phase_t;

    // configuration
    logic [COORD_BITS-1:0] max_x_reg, max_y_reg;
    logic [THR_W-1:0]      thr_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= MAX_X_INIT;
            max_y_reg <= MAX_Y_INIT;
            thr_reg   <= THR_RESET;
            gain_reg  <= GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_SCREEN_MAX_X:    max_x_reg <= pwdata[COORD_BITS-1:0];
                REG_SCREEN_MAX_Y:    max_y_reg <= pwdata[COORD_BITS-1:0];
                REG_ACCEL_THRESHOLD: thr_reg   <= pwdata[THR_W-1:0];
                REG_ACCEL_GAIN:      gain_reg  <= pwdata[GAIN_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SCREEN_MAX_X:    prdata = DATA_W'(max_x_reg);
            REG_SCREEN_MAX_Y:    prdata = DATA_W'(max_y_reg);
            REG_ACCEL_THRESHOLD: prdata = DATA_W'(thr_reg);
            REG_ACCEL_GAIN:      prdata = DATA_W'(gain_reg);
            default:             prdata = '0;
        endcase
    end

    // input register
    logic       s1_valid_reg, s1_valid_next;
    byte_word_t s1_word_reg;
    logic       s1_fire, s1_result, out_space, byte_fire;

    // packet state
    phase_t                phase_reg, phase_next, phase_eff;
    logic [BYTE_W-1:0]     header_reg, header_next;
    logic [BYTE_W-1:0]     xbyte_reg, xbyte_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next, pos_x_new;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next, pos_y_new;

    // result register
    logic      pkt_valid_reg, pkt_valid_next;
    pkt_word_t pkt_word_reg, pkt_word_new;

    // motion datapath
    logic [BYTE_W:0]              mag_x, mag_y;
    logic                         accel;
    logic signed [MOTION_W-1:0]   dx_raw, dy_raw, gain_s, dx, dy;
    logic signed [SUM_W-1:0]      nx, ny, max_x_s, max_y_s;
    logic [EXT_W-1:0]             ext_x, ext_y;

    assign out_space  = !pkt_valid_reg || pkt_ready;
    assign s1_fire    = s1_valid_reg && (!s1_result || out_space);
    assign byte_ready = !s1_valid_reg || s1_fire;
    assign byte_fire  = byte_valid && byte_ready;

    always_comb
    begin
        if (s1_word_reg.realign)
            phase_eff = PH_HDR;
        else
            phase_eff = phase_reg;
    end

    assign s1_result = (phase_eff == PH_Y);

    always_comb
    begin
        mag_x  = xbyte_reg[BYTE_W-1] ? ((BYTE_W+1)'(256) - {1'b0, xbyte_reg})
                                     : {1'b0, xbyte_reg};
        mag_y  = s1_word_reg.data_byte[BYTE_W-1]
                     ? ((BYTE_W+1)'(256) - {1'b0, s1_word_reg.data_byte})
                     : {1'b0, s1_word_reg.data_byte};
        accel  = (mag_x > (BYTE_W+1)'(thr_reg)) || (mag_y > (BYTE_W+1)'(thr_reg));
        dx_raw = MOTION_W'($signed(xbyte_reg));
        dy_raw = MOTION_W'($signed(s1_word_reg.data_byte));
        gain_s = $signed(MOTION_W'(gain_reg));
        dx     = accel ? MOTION_W'(dx_raw * gain_s) : dx_raw;
        dy     = accel ? MOTION_W'(dy_raw * gain_s) : dy_raw;

        nx      = $signed(SUM_W'(pos_x_reg)) + SUM_W'(dx);
        ny      = $signed(SUM_W'(pos_y_reg)) - SUM_W'(dy);
        max_x_s = $signed(SUM_W'(max_x_reg));
        max_y_s = $signed(SUM_W'(max_y_reg));

        if (nx[SUM_W-1])
            pos_x_new = '0;
        else if (nx > max_x_s)
            pos_x_new = max_x_reg;
        else
            pos_x_new = nx[COORD_BITS-1:0];

        if (ny[SUM_W-1])
            pos_y_new = '0;
        else if (ny > max_y_s)
            pos_y_new = max_y_reg;
        else
            pos_y_new = ny[COORD_BITS-1:0];

        ext_x = EXT_W'(pos_x_new);
        ext_y = EXT_W'(pos_y_new);
        pkt_word_new.cursor_x     = ext_x[CURSOR_W-1:0];
        pkt_word_new.cursor_y     = ext_y[CURSOR_W-1:0];
        pkt_word_new.left_button  = header_reg[LEFT_BIT];
        pkt_word_new.right_button = header_reg[RIGHT_BIT];
    end

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        xbyte_next  = xbyte_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        if (s1_fire)
        begin
            case (phase_eff)
                PH_X:
                begin
                    xbyte_next = s1_word_reg.data_byte;
                    phase_next = PH_Y;
                end
                PH_Y:
                begin
                    pos_x_next = pos_x_new;
                    pos_y_next = pos_y_new;
                    phase_next = PH_HDR;
                end
                default:
                begin
                    header_next = s1_word_reg.data_byte;
                    phase_next  = PH_X;
                end
            endcase
        end
    end

    always_comb
    begin
        if (byte_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_fire && s1_result)
            pkt_valid_next = 1'b1;
        else if (pkt_ready)
            pkt_valid_next = 1'b0;
        else
            pkt_valid_next = pkt_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pkt_valid_reg <= 1'b0;
            phase_reg     <= PH_HDR;
            header_reg    <= '0;
            xbyte_reg     <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            pkt_valid_reg <= pkt_valid_next;
            phase_reg     <= phase_next;
            header_reg    <= header_next;
            xbyte_reg     <= xbyte_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_fire)
            s1_word_reg <= byte_word;
        if (s1_fire && s1_result)
            pkt_word_reg <= pkt_word_new;
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt_word  = pkt_word_reg;

    // checks
    logic [EXT_W-1:0] chk_x;
    assign chk_x = EXT_W'(pos_x_reg);

    `include "bus_mouse_packet_tracker_assert.svh"

    `BMPT_ASSERT_NXT(a_pos_x_in_bounds, s1_fire && s1_result, pos_x_reg <= max_x_reg)
    `BMPT_ASSERT_NXT(a_pos_y_in_bounds, s1_fire && s1_result, pos_y_reg <= max_y_reg)
    `BMPT_ASSERT_IMP(a_word_tracks_pos, pkt_valid_reg, pkt_word_reg.cursor_x == chk_x[CURSOR_W-1:0])
    `BMPT_ASSERT_IMP(a_stall_cause, !byte_ready, s1_valid_reg && pkt_valid_reg && !pkt_ready)

endmodule
